// File: sv/srat_pkg.sv
// Shared types and codes for the segment range address translator.
// No dependencies; the top level, srat_cmp and the bench import this package.
package srat_pkg;

	localparam int ADDR_W = 64;

	// Operation codes; the high op bit selects translate.
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;

	// Result status codes.
	localparam logic [2:0] STAT_TRANSLATED = 3'd0;
	localparam logic [2:0] STAT_PASSED     = 3'd1;
	localparam logic [2:0] STAT_UNMAPPED   = 3'd2;
	localparam logic [2:0] STAT_STORED     = 3'd3;
	localparam logic [2:0] STAT_FULL       = 3'd4;
	localparam logic [2:0] STAT_CLEARED    = 3'd5;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] virt_addr;
		logic [ADDR_W-1:0] phys_base;
		logic [ADDR_W-1:0] seg_size;
	} srat_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] phys_addr;
		logic [2:0]        status;
	} srat_out_t;

	// One stored segment as held in the table RAM.
	typedef struct packed {
		logic [ADDR_W-1:0] virt_base;
		logic [ADDR_W-1:0] phys_base;
		logic [ADDR_W-1:0] length;
	} srat_seg_t;

	// Outcome of one range compare against the current best match.
	typedef struct packed {
		logic              hit;
		logic              take;
		logic [ADDR_W-1:0] offset;
	} srat_cmp_t;

endpackage

// File: sv/segment_range_address_translator_unit.sv
// Top level of the segment range address translator.
// Depends on srat_pkg, srat_ram and srat_cmp.
//
// Command-style segment table translator. Pulse start with a command beat on
// cmd while busy is low; the beat is taken at that edge. Every command gives
// exactly one result beat: done is high for one cycle with the beat on
// result, and the receiver cannot stall it, so sample it then. Clear and add
// answer at the edge after the command and never raise busy, so they may be
// issued every cycle. A translate with the table disabled (translate_enable
// low) or with no segment holding a nonzero physical base passes the address
// through, also answering at the next edge. Any other translate scans the
// stored segments one per cycle through the single read port of the table
// RAM and one shared range comparator: busy stays high through the scan
// and the final state, and done follows as busy falls. The lowest matching
// virtual base wins (earlier entry on a tie); the result is addr - base +
// phys mod 2^64, added in the final state. translate_enable is written through
// cfg_wr_en / cfg_wr_data and should change only while the block is idle.
// Reset clears the segment count; the table RAM itself needs no clearing.
module segment_range_address_translator_unit #(
	parameter int MAX_SEGMENTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                start,
	input  srat_pkg::srat_in_t  cmd,
	output logic                busy,
	output logic                done,
	output srat_pkg::srat_out_t result
);
	import srat_pkg::*;

	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int SEG_W = $bits(srat_seg_t);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	// control state
	logic [1:0]       state_q;
	logic             enable_q;
	logic [CNT_W-1:0] count_q;
	logic             any_nz_q;
	logic [CNT_W-1:0] scan_q;
	logic             rdv_q;
	logic             found_q;
	logic             done_q;

	// payload state
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] best_base_q;
	logic [ADDR_W-1:0] best_off_q;
	logic [ADDR_W-1:0] best_phys_q;
	srat_out_t         result_q;

	logic       accept;
	logic       table_full;
	logic       wr_en;
	srat_seg_t  wr_seg;
	srat_seg_t  rd_seg;
	srat_cmp_t  cmp_res;
	logic       take;
	logic       res_load;
	srat_out_t  res_next;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign table_full = (count_q >= CNT_W'(MAX_SEGMENTS));

	// Append a segment at the current fill count.
	assign wr_en  = accept && (cmd.op == OP_ADD) && !table_full;
	assign wr_seg = '{virt_base: cmd.virt_addr, phys_base: cmd.phys_base,
		length: cmd.seg_size};

	srat_ram #(
		.WIDTH (SEG_W),
		.DEPTH (MAX_SEGMENTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_seg),
		.rd_addr (scan_q[IDX_W-1:0]),
		.rd_data (rd_seg)
	);

	// Compare the entry read last cycle against the held address.
	srat_cmp u_cmp (
		.addr      (addr_q),
		.seg       (rd_seg),
		.best_base (best_base_q),
		.found     (found_q),
		.res       (cmp_res)
	);

	assign take = (state_q == ST_SCAN) && rdv_q && cmp_res.take;

	// Build the next result beat: immediate answers at accept, scan
	// answers at the final state.
	always_comb begin
		res_load = 1'b0;
		res_next = '0;
		priority if (accept) begin
			res_load = 1'b1;
			priority if (cmd.op == OP_CLEAR) begin
				res_next.status = STAT_CLEARED;
			end else if (cmd.op == OP_ADD) begin
				res_next.status = table_full ? STAT_FULL : STAT_STORED;
			end else if (!enable_q || !any_nz_q) begin
				res_next.phys_addr = cmd.virt_addr;
				res_next.status    = STAT_PASSED;
			end else begin
				// scan starts; no beat yet
				res_load = 1'b0;
			end
		end else if (state_q == ST_FIN) begin
			res_load = 1'b1;
			if (found_q) begin
				res_next.phys_addr = best_off_q + best_phys_q;
				res_next.status    = STAT_TRANSLATED;
			end else begin
				res_next.status = STAT_UNMAPPED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			enable_q <= 1'b1;
			count_q  <= '0;
			any_nz_q <= 1'b0;
			scan_q   <= '0;
			rdv_q    <= 1'b0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= res_load;
			if (cfg_wr_en) begin
				enable_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (cmd.op == OP_CLEAR) begin
							count_q  <= '0;
							any_nz_q <= 1'b0;
						end else if (cmd.op == OP_ADD) begin
							if (!table_full) begin
								count_q <= count_q + CNT_W'(1);
								if (cmd.phys_base != '0) begin
									any_nz_q <= 1'b1;
								end
							end
						end else if (enable_q && any_nz_q) begin
							state_q <= ST_SCAN;
							scan_q  <= '0;
							rdv_q   <= 1'b0;
							found_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					// advance the read pointer until every entry is issued,
					// then let the last read drain through the comparator
					if (scan_q < count_q) begin
						scan_q <= scan_q + CNT_W'(1);
						rdv_q  <= 1'b1;
					end else begin
						rdv_q   <= 1'b0;
						state_q <= ST_FIN;
					end
					if (take) begin
						found_q <= 1'b1;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: hold the address, the best match so far and the result beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= cmd.virt_addr;
		end
		if (take) begin
			best_base_q <= rd_seg.virt_base;
			best_off_q  <= cmp_res.offset;
			best_phys_q <= rd_seg.phys_base;
		end
		if (res_load) begin
			result_q <= res_next;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: sv/srat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module srat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: sv/srat_cmp.sv
// Range comparator for one stored segment against the address being translated.
// Depends on srat_pkg.
module srat_cmp (
	input  logic [srat_pkg::ADDR_W-1:0] addr,
	input  srat_pkg::srat_seg_t         seg,
	input  logic [srat_pkg::ADDR_W-1:0] best_base,
	input  logic                        found,
	output srat_pkg::srat_cmp_t         res
);
	import srat_pkg::*;

	logic [ADDR_W:0] diff;
	logic            no_borrow;

	assign diff      = {1'b0, addr} - {1'b0, seg.virt_base};
	assign no_borrow = ~diff[ADDR_W];

	always_comb begin
		// zero length matches the exact base only
		if (seg.length == '0) begin
			res.hit = (addr == seg.virt_base);
		end else begin
			res.hit = no_borrow && (diff[ADDR_W-1:0] < seg.length);
		end
		// strict compare keeps the earlier entry on equal bases
		res.take   = res.hit && (!found || (seg.virt_base < best_base));
		res.offset = diff[ADDR_W-1:0];
	end

endmodule

// File: bench/tb_segment_range_address_translator_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for segment_range_address_translator_unit: directed and random command beats.
// Depends on srat_pkg and the unit itself; it predicts every result beat internally.
module tb_segment_range_address_translator_unit;
	import srat_pkg::*;

	localparam int MAX_SEGMENTS = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_GAP      = 16;

	// Translate is any op with the high bit set; op 3 is the unused alias.
	localparam logic [1:0] OP_XLATE     = 2'd2;
	localparam logic [1:0] OP_XLATE_ALT = 2'd3;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      cfg_wr_en   = 1'b0;
	logic      cfg_wr_data = 1'b0;
	logic      start       = 1'b0;
	srat_in_t  cmd         = '0;
	logic      busy;
	logic      done;
	srat_out_t result;

	// Shadow copy of the segment table and the enable register.
	logic [63:0] tbl_virt [MAX_SEGMENTS];
	logic [63:0] tbl_phys [MAX_SEGMENTS];
	logic [63:0] tbl_len  [MAX_SEGMENTS];
	int          tbl_count  = 0;
	logic        tbl_any_nz = 1'b0;
	logic        xlate_en   = 1'b1;

	srat_out_t expected_results [$];
	int        fail_count   = 0;
	int        beats_issued = 0;
	int        idle_pct     = 33;
	int        cycle_count  = 0;

	segment_range_address_translator_unit #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.result     (result)
	);

	always #4 clk = ~clk;

	// Hard stop in case a beat never gets taken or a result never shows up.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("segment_range_address_translator_unit regression: fail");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic srat_in_t make_beat(input logic [1:0] op, input logic [63:0] va,
			input logic [63:0] pb, input logic [63:0] sz);
		srat_in_t b;
		b.op        = op;
		b.virt_addr = va;
		b.phys_base = pb;
		b.seg_size  = sz;
		return b;
	endfunction

	// Apply one command to the shadow table and return the result beat it must produce.
	function automatic srat_out_t predict_result(input srat_in_t c);
		srat_out_t r;
		logic      found;
		logic      hit;
		int        best;
		int        i;
		r.phys_addr = '0;
		r.status    = STAT_CLEARED;
		found       = 1'b0;
		best        = 0;
		if (c.op == OP_CLEAR) begin
			tbl_count  = 0;
			tbl_any_nz = 1'b0;
		end else if (c.op == OP_ADD) begin
			if (tbl_count >= MAX_SEGMENTS) begin
				r.status = STAT_FULL;
			end else begin
				tbl_virt[tbl_count] = c.virt_addr;
				tbl_phys[tbl_count] = c.phys_base;
				tbl_len[tbl_count]  = c.seg_size;
				if (c.phys_base != '0)
					tbl_any_nz = 1'b1;
				tbl_count++;
				r.status = STAT_STORED;
			end
		end else if (!xlate_en || !tbl_any_nz) begin
			r.phys_addr = c.virt_addr;
			r.status    = STAT_PASSED;
		end else begin
			for (i = 0; i < tbl_count; i++) begin
				// Zero length means the exact base only; ranges never wrap.
				if (tbl_len[i] == '0)
					hit = (c.virt_addr == tbl_virt[i]);
				else
					hit = (c.virt_addr >= tbl_virt[i]) &&
						((c.virt_addr - tbl_virt[i]) < tbl_len[i]);
				// Strict compare keeps the earlier entry on equal bases.
				if (hit && (!found || tbl_virt[i] < tbl_virt[best])) begin
					best  = i;
					found = 1'b1;
				end
			end
			if (found) begin
				r.phys_addr = c.virt_addr - tbl_virt[best] + tbl_phys[best];
				r.status    = STAT_TRANSLATED;
			end else begin
				r.status = STAT_UNMAPPED;
			end
		end
		return r;
	endfunction

	// Send one command beat. Hold start high across back-to-back beats; drop it only for
	// an idle gap, so start never sees two assignments in one time step.
	task automatic issue_command(input srat_in_t beat);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= beat;
		do @(posedge clk); while (busy);
		expected_results = {expected_results, predict_result(beat)};
		beats_issued++;
	endtask

	// Write translate_enable once the block has drained every outstanding result.
	task automatic write_translate_enable(input logic en);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= en;
		@(posedge clk);
		xlate_en = en;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Compare each result beat with the oldest prediction; the receiver cannot stall.
	always @(posedge clk) begin : result_check
		srat_out_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat: phys_addr=%h status=%0d",
					result.phys_addr, result.status);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.phys_addr !== want.phys_addr) begin
					$error("phys_addr: expected %h, got %h", want.phys_addr, result.phys_addr);
					fail_count++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fail_count++;
				end
			end
		end
	end

	// Empty table after reset: every translate passes through, op 3 included.
	task automatic test_reset_state();
		issue_command(make_beat(OP_XLATE, 64'h0, 64'h0, 64'h0));
		issue_command(make_beat(OP_XLATE_ALT, ALL_ONES, ALL_ONES, ALL_ONES));
	endtask

	// Range boundaries, zero-length segments, zero physical base, top of address space.
	task automatic test_range_edges();
		issue_command(make_beat(OP_ADD, 64'h1000, 64'h0, 64'h100));
		// Only a zero physical base stored so far: still pass-through.
		issue_command(make_beat(OP_XLATE, 64'h1080, 64'h0, 64'h0));
		issue_command(make_beat(OP_ADD, 64'h5000, ALL_ONES, 64'h0));
		issue_command(make_beat(OP_XLATE, 64'h5000, 64'h0, 64'h0));
		issue_command(make_beat(OP_XLATE, 64'h5001, 64'h0, 64'h0));
		issue_command(make_beat(OP_XLATE, 64'h10FF, 64'h0, 64'h0));
		issue_command(make_beat(OP_XLATE, 64'h1100, 64'h0, 64'h0));
		issue_command(make_beat(OP_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10, 64'h10));
		issue_command(make_beat(OP_XLATE, ALL_ONES, 64'h0, 64'h0));
	endtask

	// Overlapping segments: lowest virtual base wins, earlier entry on a tie.
	task automatic test_overlap_priority();
		issue_command(make_beat(OP_ADD, 64'h3000, 64'hA000_0000, 64'h1000));
		issue_command(make_beat(OP_ADD, 64'h2800, 64'hB000_0000, 64'h1000));
		issue_command(make_beat(OP_ADD, 64'h2800, 64'hC000_0000, 64'h2000));
		issue_command(make_beat(OP_XLATE, 64'h3100, 64'h0, 64'h0));
	endtask

	// Fill the table, overflow it, and wrap the sum past 2^64 through op 3.
	task automatic test_table_full();
		issue_command(make_beat(OP_ADD, 64'h2000, 64'hFFFF_FFFF_FFFF_FF00, 64'h200));
		issue_command(make_beat(OP_ADD, ALL_ONES, 64'h1, ALL_ONES));
		issue_command(make_beat(OP_ADD, 64'h9000, 64'h1, 64'h10));
		issue_command(make_beat(OP_XLATE_ALT, 64'h2180, 64'h0, 64'h0));
	endtask

	// Disabled translation passes through; a clear drops the nonzero-base flag.
	task automatic test_translate_disabled();
		write_translate_enable(1'b0);
		issue_command(make_beat(OP_XLATE, 64'h3100, 64'h0, 64'h0));
		write_translate_enable(1'b1);
		issue_command(make_beat(OP_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES));
		issue_command(make_beat(OP_XLATE, 64'h3100, 64'h0, 64'h0));
	endtask

	// Mostly well-formed rounds: clear, fill with segments clustered in one region,
	// then translate around them. A little noise and an occasional enable flip.
	task automatic test_random_traffic(input int sender_idle, input int n_beats);
		int          stop_at;
		int          n_seg;
		int          n_xl;
		int          k;
		int          pick;
		logic [63:0] region;
		logic [63:0] len;
		logic [63:0] pb;
		logic [63:0] addr;
		logic [1:0]  op;
		idle_pct = sender_idle;
		stop_at  = beats_issued + n_beats;
		while (beats_issued < stop_at) begin
			if ($urandom_range(5) == 0)
				write_translate_enable($urandom_range(4) != 0);
			if ($urandom_range(7) == 0)
				issue_command(make_beat(2'($urandom_range(3)), rand64(), rand64(), rand64()));
			issue_command(make_beat(OP_CLEAR, rand64(), rand64(), rand64()));
			case ($urandom_range(3))
				0: region = rand64() & ~64'hFFFF;
				1: region = 64'h0;
				2: region = 64'hFFFF_FFFF_FFFF_0000;
				default: region = rand64();
			endcase
			n_seg = $urandom_range(1, MAX_SEGMENTS + 2);
			for (k = 0; k < n_seg; k++) begin
				case ($urandom_range(7))
					0: len = 64'h0;
					6: len = rand64();
					7: len = ALL_ONES;
					default: len = 64'($urandom_range(1, 'h2000));
				endcase
				pb = ($urandom_range(7) == 0) ? 64'h0 : rand64();
				issue_command(make_beat(OP_ADD, region + 64'($urandom_range(0, 'h3000)), pb, len));
			end
			n_xl = $urandom_range(2, 12);
			for (k = 0; k < n_xl; k++) begin
				pick = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
				case ($urandom_range(9))
					0, 1, 2, 3:
						addr = tbl_virt[pick] +
							((tbl_len[pick] == '0) ? 64'h0 : rand64() % tbl_len[pick]);
					4: addr = tbl_virt[pick];
					5: addr = tbl_virt[pick] + tbl_len[pick];
					6: addr = tbl_virt[pick] - 64'h1;
					7: addr = region + 64'($urandom_range(0, 'h5000));
					8: addr = ALL_ONES - 64'($urandom_range(0, 'h20));
					default: addr = rand64();
				endcase
				op = ($urandom_range(3) == 0) ? OP_XLATE_ALT : OP_XLATE;
				issue_command(make_beat(op, addr, rand64(), rand64()));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_range_edges();
		test_overlap_priority();
		test_table_full();
		test_translate_disabled();

		// Sender idles 33%, then 48%, then runs flat out.
		test_random_traffic(33, 400);
		test_random_traffic(48, 400);
		test_random_traffic(0, 400);

		// Drop start, drain outstanding results, then leave time for stray beats.
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (2 * MAX_SEGMENTS + 4) @(posedge clk);

		if (fail_count == 0)
			$display("segment_range_address_translator_unit regression: pass");
		else
			$display("segment_range_address_translator_unit regression: fail");
		$finish;
	end

endmodule

// File: sim.f
sv/srat_pkg.sv
sv/srat_ram.sv
sv/srat_cmp.sv
sv/segment_range_address_translator_unit.sv
bench/tb_segment_range_address_translator_unit.sv
